// ===== hw/rtl/fem_shape_function_evaluator_unit_defines.svh =====
// Assertion macros shared by the checker of the shape-function evaluator.
// Depends on nothing; included by the checker file only.
`ifndef FEM_SHAPE_FUNCTION_EVALUATOR_UNIT_DEFINES_SVH
`define FEM_SHAPE_FUNCTION_EVALUATOR_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FSE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fse_pkg.sv =====
// Package of the shape-function evaluator: element codes and fixed formats.
// Depends on nothing; used by the top level.
package fse_pkg;

    // Element kind codes of the configuration register.
    typedef enum logic [2:0] {
        EK_SEG2     = 3'd0,
        EK_TRI3     = 3'd1,
        EK_TRI6     = 3'd2,
        EK_TRI6_ALT = 3'd3,
        EK_QUAD4    = 3'd4,
        EK_QUAD8    = 3'd5,
        EK_QUAD8_ALT= 3'd6,
        EK_HEX8     = 3'd7
    } elem_kind_t;

    localparam int COORD_W = 16;
    localparam int OUT_W   = 20;
    localparam int NODE_W  = 3;

endpackage

// ===== hw/rtl/fem_shape_function_evaluator_unit.sv =====
// Top level of the finite-element shape-function evaluator.
// Depends on fse_pkg for element codes.
//
// Channel   Ports                                         Handshake
// config    element_kind_we, element_kind_wdata           write on enable
// input     start, busy, coord_a, coord_b, coord_c        start & !busy
// result    result_valid, node_index, shape_value,        one-cycle strobe
//           deriv_first, deriv_second, deriv_third, last_node
//
// A point has 2 to 8 nodes, walked in order by the single node sequencer stage.
// Behind it a five-stage pipeline (factors, first product, first rounding,
// second product, rounding and saturation) moves one node per cycle. busy is
// high while the sequencer holds a point with nodes left after the current
// cycle. The receiver cannot stall, so the pipeline never stops. Reset clears
// the valid bits and the element kind returns to hexahedron.
module fem_shape_function_evaluator_unit #(
    parameter int FRAC_BITS = 14,
    parameter int MAX_NODES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                element_kind_we,
    input  logic [2:0]          element_kind_wdata,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  coord_a,
    input  logic signed [15:0]  coord_b,
    input  logic signed [15:0]  coord_c,
    output logic                result_valid,
    output logic [2:0]          node_index,
    output logic signed [19:0]  shape_value,
    output logic signed [19:0]  deriv_first,
    output logic signed [19:0]  deriv_second,
    output logic signed [19:0]  deriv_third,
    output logic                last_node
);

    // Working width: factors hold values below 32*one, products twice the width.
    localparam int FW = FRAC_BITS + 6;
    localparam int PW = 2 * FW;
    localparam logic signed [FW-1:0] ONE  = FW'(1) <<< FRAC_BITS;
    localparam logic signed [FW-1:0] ONE3 = FW'(3) <<< FRAC_BITS;
    localparam logic signed [FW-1:0] ONE4 = FW'(4) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] OMAX = PW'(524287);
    localparam logic signed [PW-1:0] OMIN = -PW'(524288);

    // One term: value = sgnv * rnd(rnd(f0*f1 >> F) * f2 >> F+ex) or plain.
    typedef struct packed {
        logic signed [FW-1:0] f0;
        logic signed [FW-1:0] f1;
        logic signed [FW-1:0] f2;
        logic                 three;   // product of three factors
        logic                 mul;     // any product at all
        logic [1:0]           ex;      // extra right shift
        logic                 neg;     // negate after rounding
    } term_t;

    typedef struct packed {
        logic                 vld;
        logic [2:0]           idx;
        logic                 last;
    } tag_t;

    fse_pkg::elem_kind_t kind_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= fse_pkg::EK_HEX8;
        end
        else if (element_kind_we)
        begin
            kind_reg <= fse_pkg::elem_kind_t'(element_kind_wdata);
        end
    end

    // Node sequencer: holds the point and walks its nodes.
    logic signed [FW-1:0] a_reg, b_reg, c_reg;
    logic        seq_vld_reg, seq_vld_next;
    logic [2:0]  seq_cnt_reg, seq_cnt_next;
    logic [2:0]  seq_last;
    logic [3:0]  nodes;
    logic        accept;

    always_comb
    begin
        case (kind_reg)
            fse_pkg::EK_SEG2:                         nodes = 4'd2;
            fse_pkg::EK_TRI3:                         nodes = 4'd3;
            fse_pkg::EK_TRI6, fse_pkg::EK_TRI6_ALT:   nodes = 4'd6;
            fse_pkg::EK_QUAD4:                        nodes = 4'd4;
            default:                                  nodes = 4'd8;
        endcase
        if (nodes > 4'(MAX_NODES))
        begin
            nodes = 4'(MAX_NODES);
        end
        seq_last = 3'(nodes - 4'd1);
    end

    assign busy   = seq_vld_reg && (seq_cnt_reg != seq_last);
    assign accept = start && !busy;

    always_comb
    begin
        seq_vld_next = seq_vld_reg;
        seq_cnt_next = seq_cnt_reg;
        if (accept)
        begin
            seq_vld_next = 1'b1;
            seq_cnt_next = 3'd0;
        end
        else if (seq_vld_reg)
        begin
            seq_vld_next = 1'b0;
        end
        if (!accept && busy)
        begin
            seq_vld_next = 1'b1;
            seq_cnt_next = seq_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_vld_reg <= 1'b0;
            seq_cnt_reg <= 3'd0;
        end
        else
        begin
            seq_vld_reg <= seq_vld_next;
            seq_cnt_reg <= seq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= FW'(coord_a);
            b_reg <= FW'(coord_b);
            c_reg <= FW'(coord_c);
        end
    end

    // Term selection for the current node: four terms per node.
    term_t t_nv, t_d1, t_d2, t_d3;
    logic [2:0] s;

    function automatic term_t mk(input logic signed [FW-1:0] x0,
                                 input logic signed [FW-1:0] x1,
                                 input logic signed [FW-1:0] x2,
                                 input logic th, input logic mu,
                                 input logic [1:0] e, input logic ng);
        term_t t;
        t.f0 = x0; t.f1 = x1; t.f2 = x2;
        t.three = th; t.mul = mu; t.ex = e; t.neg = ng;
        return t;
    endfunction

    always_comb
    begin
        logic signed [FW-1:0] a, b, c, z, fx, fy, fz, pa, ma, pb, mb;
        logic signed [FW-1:0] a2, a4, a8, b2, b4, b8, c2, c4, ab4;
        logic sx, sy, sz;
        a = a_reg; b = b_reg; c = c_reg; z = '0;
        // Scaled coordinates used by the quadratic elements.
        a2 = a <<< 1; a4 = a <<< 2; a8 = a <<< 3;
        b2 = b <<< 1; b4 = b <<< 2; b8 = b <<< 3;
        c2 = c <<< 1; c4 = c <<< 2;
        ab4 = (a + b) <<< 2;
        s = seq_cnt_reg;
        if (kind_reg == fse_pkg::EK_TRI6_ALT)
        begin
            case (seq_cnt_reg)
                3'd1: s = 3'd2;
                3'd2: s = 3'd4;
                3'd3: s = 3'd1;
                3'd4: s = 3'd3;
                default: s = seq_cnt_reg;
            endcase
        end
        else if (kind_reg == fse_pkg::EK_QUAD8_ALT)
        begin
            s = seq_cnt_reg[2] ? {seq_cnt_reg[1:0], 1'b1} : {seq_cnt_reg[1:0], 1'b0};
        end
        sx = (s == 3'd0) || (s == 3'd3) || (s == 3'd4) || (s == 3'd7);
        sy = !s[1];
        sz = !s[2];
        fx = sx ? ONE - a : ONE + a;
        fy = sy ? ONE - b : ONE + b;
        fz = sz ? ONE - c : ONE + c;
        pa = ONE + a; ma = ONE - a; pb = ONE + b; mb = ONE - b;
        t_nv = mk(z, z, z, 1'b0, 1'b0, 2'd0, 1'b0);
        t_d1 = t_nv; t_d2 = t_nv; t_d3 = t_nv;
        case (kind_reg)
            fse_pkg::EK_SEG2:
            begin
                // Plain term with mul off rounds f0 by ex.
                t_nv = mk(fx, z, z, 1'b0, 1'b0, 2'd1, 1'b0);
                t_d1 = mk(sx ? -(ONE >>> 1) : (ONE >>> 1), z, z, 1'b0, 1'b0, 2'd0, 1'b0);
            end
            fse_pkg::EK_TRI3:
            begin
                case (s)
                    3'd0: begin t_nv.f0 = a; t_d1.f0 = ONE; end
                    3'd1: begin t_nv.f0 = b; t_d2.f0 = ONE; end
                    default: begin t_nv.f0 = c; t_d1.f0 = -ONE; t_d2.f0 = -ONE; end
                endcase
            end
            fse_pkg::EK_TRI6, fse_pkg::EK_TRI6_ALT:
            begin
                case (s)
                    3'd0: begin
                        t_nv = mk(a, a2 - ONE, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d1.f0 = a4 - ONE;
                    end
                    3'd1: begin
                        t_nv = mk(a4, b, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d1.f0 = b4; t_d2.f0 = a4;
                    end
                    3'd2: begin
                        t_nv = mk(b, b2 - ONE, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d2.f0 = b4 - ONE;
                    end
                    3'd3: begin
                        t_nv = mk(b4, c, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d1.f0 = -b4; t_d2.f0 = ONE4 - b8 - a4;
                    end
                    3'd4: begin
                        t_nv = mk(c, c2 - ONE, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d1.f0 = ab4 - ONE3; t_d2.f0 = ab4 - ONE3;
                    end
                    default: begin
                        t_nv = mk(c4, a, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d1.f0 = ONE4 - a8 - b4; t_d2.f0 = -a4;
                    end
                endcase
            end
            fse_pkg::EK_QUAD4:
            begin
                t_nv = mk(fx, fy, z, 1'b0, 1'b1, 2'd2, 1'b0);
                t_d1 = mk(fy, z, z, 1'b0, 1'b0, 2'd2, sx);
                t_d2 = mk(fx, z, z, 1'b0, 1'b0, 2'd2, sy);
            end
            fse_pkg::EK_QUAD8, fse_pkg::EK_QUAD8_ALT:
            begin
                case (s)
                    3'd0: begin
                        t_nv = mk(ma, mb, ONE + a + b, 1'b1, 1'b1, 2'd2, 1'b1);
                        t_d1 = mk(mb, a2 + b, z, 1'b0, 1'b1, 2'd2, 1'b0);
                        t_d2 = mk(ma, b2 + a, z, 1'b0, 1'b1, 2'd2, 1'b0);
                    end
                    3'd1: begin
                        t_nv = mk(ma, pa, mb, 1'b1, 1'b1, 2'd1, 1'b0);
                        t_d1 = mk(a, b - ONE, z, 1'b0, 1'b1, 2'd0, 1'b0);
                        t_d2 = mk(a - ONE, a + ONE, z, 1'b0, 1'b1, 2'd1, 1'b0);
                    end
                    3'd2: begin
                        t_nv = mk(pa, mb, ONE - a + b, 1'b1, 1'b1, 2'd2, 1'b1);
                        t_d1 = mk(mb, a2 - b, z, 1'b0, 1'b1, 2'd2, 1'b0);
                        t_d2 = mk(pa, b2 - a, z, 1'b0, 1'b1, 2'd2, 1'b0);
                    end
                    3'd3: begin
                        t_nv = mk(mb, pb, pa, 1'b1, 1'b1, 2'd1, 1'b0);
                        t_d1 = mk(mb, pb, z, 1'b0, 1'b1, 2'd1, 1'b0);
                        t_d2 = mk(b, pa, z, 1'b0, 1'b1, 2'd0, 1'b1);
                    end
                    3'd4: begin
                        t_nv = mk(pa, pb, ONE - a - b, 1'b1, 1'b1, 2'd2, 1'b1);
                        t_d1 = mk(pb, a2 + b, z, 1'b0, 1'b1, 2'd2, 1'b0);
                        t_d2 = mk(pa, b2 + a, z, 1'b0, 1'b1, 2'd2, 1'b0);
                    end
                    3'd5: begin
                        t_nv = mk(ma, pa, pb, 1'b1, 1'b1, 2'd1, 1'b0);
                        t_d1 = mk(a, pb, z, 1'b0, 1'b1, 2'd0, 1'b1);
                        t_d2 = mk(ma, pa, z, 1'b0, 1'b1, 2'd1, 1'b0);
                    end
                    3'd6: begin
                        t_nv = mk(ma, pb, ONE + a - b, 1'b1, 1'b1, 2'd2, 1'b1);
                        t_d1 = mk(pb, a2 - b, z, 1'b0, 1'b1, 2'd2, 1'b0);
                        t_d2 = mk(ma, b2 - a, z, 1'b0, 1'b1, 2'd2, 1'b0);
                    end
                    default: begin
                        t_nv = mk(mb, pb, ma, 1'b1, 1'b1, 2'd1, 1'b0);
                        t_d1 = mk(b - ONE, b + ONE, z, 1'b0, 1'b1, 2'd1, 1'b0);
                        t_d2 = mk(b, a - ONE, z, 1'b0, 1'b1, 2'd0, 1'b0);
                    end
                endcase
            end
            default:
            begin
                t_nv = mk(fx, fy, fz, 1'b1, 1'b1, 2'd3, 1'b0);
                t_d1 = mk(fy, fz, z, 1'b0, 1'b1, 2'd3, sx);
                t_d2 = mk(fx, fz, z, 1'b0, 1'b1, 2'd3, sy);
                t_d3 = mk(fx, fy, z, 1'b0, 1'b1, 2'd3, sz);
            end
        endcase
    end

    // Rounding of v by 2^sh, ties away from zero.
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int sh);
        logic [PW-1:0] m;
        logic neg;
        neg = v[PW-1];
        if (sh == 0)
        begin
            return v;
        end
        m = neg ? PW'(-v) : PW'(v);
        m = (m + (PW'(1) << (sh - 1))) >> sh;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // Stage 1: registered terms.
    term_t s1_t_reg [4];
    tag_t  s1_tag_reg;
    always_ff @(posedge clk)
    begin
        s1_t_reg[0] <= t_nv;
        s1_t_reg[1] <= t_d1;
        s1_t_reg[2] <= t_d2;
        s1_t_reg[3] <= t_d3;
    end

    // Stage 2: first product.
    logic signed [PW-1:0] s2_p_reg [4];
    term_t s2_t_reg [4];
    tag_t  s2_tag_reg;
    // Stage 3: first rounding, or the full product when there is no third factor.
    logic signed [PW-1:0] s3_r_reg [4];
    term_t s3_t_reg [4];
    tag_t  s3_tag_reg;
    // Stage 4: second product.
    logic signed [PW+2:0] s4_p_reg [4];
    term_t s4_t_reg [4];
    tag_t  s4_tag_reg;
    // Stage 5: final rounding, negation and saturation.
    logic signed [19:0]   s5_o_reg [4];
    tag_t  s5_tag_reg;

    // Valid bits and node tags travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg.vld  <= seq_vld_reg;
            s1_tag_reg.idx  <= seq_cnt_reg;
            s1_tag_reg.last <= (seq_cnt_reg == seq_last);
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic signed [PW+2:0] fin;
        always_comb
        begin
            fin = '0;
            if (s4_t_reg[k].mul)
            begin
                fin = (PW+3)'(rnd(PW'(s4_p_reg[k]), FRAC_BITS + int'(s4_t_reg[k].ex)));
            end
            else
            begin
                fin = (PW+3)'(rnd(PW'(s4_p_reg[k]), int'(s4_t_reg[k].ex)));
            end
            if (s4_t_reg[k].neg)
            begin
                fin = -fin;
            end
        end

        always_ff @(posedge clk)
        begin
            s2_t_reg[k] <= s1_t_reg[k];
            s2_p_reg[k] <= s1_t_reg[k].mul ? PW'(s1_t_reg[k].f0) * PW'(s1_t_reg[k].f1)
                                           : PW'(s1_t_reg[k].f0);
            s3_t_reg[k] <= s2_t_reg[k];
            s3_r_reg[k] <= s2_t_reg[k].three ? rnd(s2_p_reg[k], FRAC_BITS)
                                             : s2_p_reg[k];
            s4_t_reg[k] <= s3_t_reg[k];
            s4_p_reg[k] <= s3_t_reg[k].three
                           ? (PW+3)'($signed(s3_r_reg[k][FW+2:0]))
                             * (PW+3)'(s3_t_reg[k].f2)
                           : (PW+3)'(s3_r_reg[k]);
            if (fin > (PW+3)'(OMAX))
            begin
                s5_o_reg[k] <= 20'sd524287;
            end
            else if (fin < (PW+3)'(OMIN))
            begin
                s5_o_reg[k] <= -20'sd524288;
            end
            else
            begin
                s5_o_reg[k] <= fin[19:0];
            end
        end
    end

    // Result outputs.
    assign result_valid = s5_tag_reg.vld;
    assign node_index   = s5_tag_reg.idx;
    assign last_node    = s5_tag_reg.last;
    assign shape_value  = s5_o_reg[0];
    assign deriv_first  = s5_o_reg[1];
    assign deriv_second = s5_o_reg[2];
    assign deriv_third  = s5_o_reg[3];

endmodule

// ===== hw/rtl/fse_checker.sv =====
// Port-level checker of the shape-function evaluator and its bind.
// Depends on the assertion macros in the defines header.
`include "fem_shape_function_evaluator_unit_defines.svh"

module fse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  node_index,
    input logic        last_node
);

    // Results of one point count up from zero.
    `FSE_ASSERT_NEXT(a_idx_seq, clk, rst_n, result_valid && !last_node, result_valid && node_index == $past(node_index) + 3'd1, "node index skipped")
    // A result after a last node starts at node zero.
    `FSE_ASSERT_NEXT(a_idx_zero, clk, rst_n, result_valid && last_node, !result_valid || node_index == 3'd0, "new point not at node zero")
    // Every element has at least two nodes, so the last node is never node zero.
    `FSE_ASSERT_IMP(a_last_pos, clk, rst_n, result_valid && last_node, node_index != 3'd0, "last node at index zero")
    // An accepted transaction shows its node zero result once it leaves the pipeline.
    `FSE_ASSERT_IMP(a_lat, clk, rst_n, start && !busy, ##6 (result_valid && node_index == 3'd0), "first node result late")

endmodule

bind fem_shape_function_evaluator_unit fse_checker u_fse_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .node_index(node_index), .last_node(last_node)
);
